// File: rtl/bqrt_pkg.sv
package bqrt_pkg;

    localparam int BYTES_W = 64;
    localparam int MONTH_W = 16;
    localparam int SLOT_W  = 4;
    localparam int FUNC_W  = 2;
    localparam int CFG_IDX_W = 2;

    // slot field is 4 bits wide, so no more than this many entries can ever be addressed
    localparam int SLOT_SPAN = 1 << SLOT_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_RESERVE  = 2'd0,
        FN_COMMIT   = 2'd1,
        FN_RELEASE  = 2'd2,
        FN_SNAPSHOT = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUOTA_EN = 2'd0,
        CFG_LIMIT    = 2'd1,
        CFG_HARD     = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_PRE,
        ST_TOT,
        ST_APPLY,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic              slot_ok;
        logic [SLOT_W-1:0] slot;
    } walk_req_t;

    typedef struct packed {
        logic               done;
        logic [BYTES_W-1:0] excl;
        logic [BYTES_W-1:0] sel;
    } walk_res_t;

    function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                   input logic [BYTES_W-1:0] b);
        logic [BYTES_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[BYTES_W] ? {BYTES_W{1'b1}} : sum[BYTES_W-1:0];
    endfunction

endpackage

// File: rtl/bqrt_ram.sv
module bqrt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bqrt_walker.sv
module bqrt_walker #(
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  bqrt_pkg::walk_req_t                     req,
    input  logic [DEPTH-1:0]                        active,
    output logic                                    rd_en,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    input  logic [bqrt_pkg::BYTES_W-1:0]            rd_data,
    output bqrt_pkg::walk_res_t                     res
);

    import bqrt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic               busy_reg;
    logic [CW-1:0]      cnt_reg;
    logic               pend_reg;
    logic [AW-1:0]      pidx_reg;
    logic [BYTES_W-1:0] acc_reg;
    logic [BYTES_W-1:0] sel_reg;
    logic               issue;
    logic               is_target;

    assign issue     = busy_reg && (cnt_reg != CW'(DEPTH));
    assign is_target = req.slot_ok && (pidx_reg == req.slot[AW-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= issue;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (issue) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (busy_reg && !pend_reg) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // the requested slot is kept apart so the caller can swap its value in or out
    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg <= '0;
            sel_reg <= '0;
        end else if (pend_reg && active[pidx_reg]) begin
            if (is_target) begin
                sel_reg <= rd_data;
            end else begin
                acc_reg <= sat_add(acc_reg, rd_data);
            end
        end
        if (issue) begin
            pidx_reg <= cnt_reg[AW-1:0];
        end
    end

    assign rd_en    = issue;
    assign rd_addr  = cnt_reg[AW-1:0];
    assign res.done = busy_reg && !issue && !pend_reg;
    assign res.excl = acc_reg;
    assign res.sel  = sel_reg;

endmodule

// File: rtl/byte_quota_reservation_tracker_top.sv
// Byte quota tracker for one monthly period with a table of reservation slots. Each beat on the
// s_ side carries an operation in s_tuser (reserve, commit, release, snapshot) and yields exactly
// one result beat on the m_ side with the admit flag, the over-quota flag, the committed byte count
// and the saturated sum of active reservations. Any operation but release starts a new period when
// its month differs from the stored one, clearing the used count and all slots. One operation at a
// time is handled, and the next beat is taken only once the result of the last one is loaded into
// the output register; the time an operation takes is set by the walk over the slot table, which
// reads one entry a cycle from the slot RAM. A new beat is taken while the previous result still
// waits on m_tready. Configuration writes are always accepted and should only be issued while no
// operation is in flight.
module byte_quota_reservation_tracker_top #(
    parameter int SLOTS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // slot [3:0], byte_count [67:4], current_month [83:68], zero fill
    input  logic [87:0]                        s_tdata,
    // func [1:0]
    input  logic [bqrt_pkg::FUNC_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // allowed [0], status [1], used_bytes [65:2], reserved_bytes [129:66], zero fill
    output logic [135:0]                       m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bqrt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bqrt_pkg::BYTES_W-1:0]       cfg_data
);

    import bqrt_pkg::*;

    localparam int DEPTH = (SLOTS < SLOT_SPAN) ? SLOTS : SLOT_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;

    logic               quota_en_reg;
    logic [BYTES_W-1:0] limit_reg;
    logic               hard_reg;

    logic [MONTH_W-1:0] stored_month_reg;
    logic               month_known_reg;
    logic [BYTES_W-1:0] used_reg;
    logic [DEPTH-1:0]   active_reg;

    func_t              func_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               slot_ok_reg;
    logic [BYTES_W-1:0] bytes_reg;

    logic [BYTES_W-1:0] pre_reg;
    logic [BYTES_W-1:0] tot_reg;
    logic               res_allowed_reg;
    logic               res_status_reg;
    logic [BYTES_W-1:0] res_reserved_reg;

    logic               m_tvalid_reg;
    logic               out_allowed_reg;
    logic               out_status_reg;
    logic [BYTES_W-1:0] out_used_reg;
    logic [BYTES_W-1:0] out_reserved_reg;

    logic               s_accept;
    logic               apply_state;
    logic               out_load;
    func_t              in_func;
    logic [SLOT_W-1:0]  in_slot;
    logic [BYTES_W-1:0] in_bytes;
    logic [MONTH_W-1:0] in_month;
    logic               new_period;
    logic               quota_on;
    logic [BYTES_W-1:0] after_bytes;
    logic               deny;
    logic               do_record;
    logic               do_free;
    logic [AW-1:0]      slot_idx;

    walk_req_t          walk_req;
    walk_res_t          walk_res;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [BYTES_W-1:0] ram_rdata;

    assign in_func  = func_t'(s_tuser);
    assign in_slot  = s_tdata[SLOT_W-1:0];
    assign in_bytes = s_tdata[SLOT_W +: BYTES_W];
    assign in_month = s_tdata[SLOT_W+BYTES_W +: MONTH_W];

    assign s_accept   = s_tvalid && s_tready;
    assign new_period = (in_func != FN_RELEASE)
                        && (!month_known_reg || (stored_month_reg != in_month));
    assign quota_on   = quota_en_reg && (limit_reg != '0);
    assign slot_idx   = slot_reg[AW-1:0];

    assign after_bytes = sat_add(tot_reg, bytes_reg);
    assign deny        = (func_reg == FN_RESERVE) && quota_on && hard_reg
                         && (after_bytes > limit_reg);
    assign do_record   = apply_state && (func_reg == FN_RESERVE) && quota_on && !deny
                         && slot_ok_reg;
    assign do_free     = apply_state && slot_ok_reg
                         && ((func_reg == FN_COMMIT) || (func_reg == FN_RELEASE));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_WALK;
            ST_WALK:  if (walk_res.done) state_next = ST_PRE;
            ST_PRE:   state_next = ST_TOT;
            ST_TOT:   state_next = ST_APPLY;
            ST_APPLY: state_next = ST_OUT;
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready    = 1'b0;
        apply_state = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_WALK:  ;
            ST_PRE:   ;
            ST_TOT:   ;
            ST_APPLY: apply_state = 1'b1;
            ST_OUT:   out_load = !m_tvalid_reg || m_tready;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quota_en_reg <= 1'b0;
            limit_reg    <= '0;
            hard_reg     <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_QUOTA_EN: quota_en_reg <= cfg_data[0];
                CFG_LIMIT:    limit_reg    <= cfg_data;
                CFG_HARD:     hard_reg     <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // period state and slot activity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_month_reg <= '0;
            month_known_reg  <= 1'b0;
            used_reg         <= '0;
            active_reg       <= '0;
        end else if (s_accept && new_period) begin
            stored_month_reg <= in_month;
            month_known_reg  <= 1'b1;
            used_reg         <= '0;
            active_reg       <= '0;
        end else begin
            if (apply_state && (func_reg == FN_COMMIT) && quota_on) begin
                used_reg <= sat_add(used_reg, bytes_reg);
            end
            if (do_record) begin
                active_reg[slot_idx] <= 1'b1;
            end else if (do_free) begin
                active_reg[slot_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg    <= in_func;
            slot_reg    <= in_slot;
            slot_ok_reg <= 32'(in_slot) < SLOTS;
            bytes_reg   <= in_bytes;
        end
        if (state_reg == ST_PRE) begin
            pre_reg <= sat_add(walk_res.excl, walk_res.sel);
        end
        if (state_reg == ST_TOT) begin
            tot_reg <= sat_add(used_reg, pre_reg);
        end
        if (apply_state) begin
            res_allowed_reg <= !deny;
            res_status_reg  <= deny;
            if (do_record) begin
                res_reserved_reg <= sat_add(walk_res.excl, bytes_reg);
            end else if (do_free) begin
                res_reserved_reg <= walk_res.excl;
            end else begin
                res_reserved_reg <= pre_reg;
            end
        end
        if (out_load) begin
            out_allowed_reg  <= res_allowed_reg;
            out_status_reg   <= res_status_reg;
            out_used_reg     <= used_reg;
            out_reserved_reg <= res_reserved_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_reserved_reg, out_used_reg, out_status_reg, out_allowed_reg};

    assign walk_req.start   = s_accept;
    assign walk_req.slot_ok = slot_ok_reg;
    assign walk_req.slot    = slot_reg;

    bqrt_walker #(
        .DEPTH (DEPTH)
    ) u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (walk_req),
        .active  (active_reg),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata),
        .res     (walk_res)
    );

    bqrt_ram #(
        .WIDTH (BYTES_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (do_record),
        .waddr (slot_idx),
        .wdata (bytes_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a result beat is only produced by the final step of an operation
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result beat raised outside output step");

    // walk completion is only seen while the sequencer waits on it
    a_walk_done: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_res.done |-> (state_reg == ST_WALK))
        else $error("slot walk finished out of sequence");

    // a slot is written only by an admitted reservation on a valid slot
    a_ram_write: assert property (@(posedge aclk) disable iff (!aresetn)
        do_record |-> (slot_ok_reg && (func_reg == FN_RESERVE) && !deny))
        else $error("slot table written by wrong operation");

    // a denied reservation never marks a free slot as recorded
    a_deny_no_record: assert property (@(posedge aclk) disable iff (!aresetn)
        (apply_state && deny && slot_ok_reg && !$past(active_reg[slot_idx]))
        |=> !active_reg[$past(slot_idx)])
        else $error("denied reservation recorded");

endmodule

// File: tb/quota_tracker_checker.sv
`timescale 1ns / 1ps

module quota_tracker_checker #(
    parameter int SLOTS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // slot [3:0], byte_count [67:4], current_month [83:68], zero fill
    input  logic [87:0]                    s_tdata,
    // func [1:0]
    input  logic [bqrt_pkg::FUNC_W-1:0]    s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // allowed [0], status [1], used_bytes [65:2], reserved_bytes [129:66], zero fill
    input  logic [135:0]                   m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [bqrt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bqrt_pkg::BYTES_W-1:0]   cfg_data,
    output int                             mismatches,
    output int                             outstanding
);

    import bqrt_pkg::*;

    typedef struct {
        logic               allowed;
        logic               status;
        logic [BYTES_W-1:0] used;
        logic [BYTES_W-1:0] reserved;
    } quota_report_t;

    logic               q_enabled;
    logic [BYTES_W-1:0] q_limit;
    logic               q_hard;
    logic [MONTH_W-1:0] period;
    logic               have_month;
    logic [BYTES_W-1:0] used_total;
    logic               slot_live [SLOTS];
    logic [BYTES_W-1:0] slot_amount [SLOTS];
    quota_report_t      quota_reports_q [$];
    int                 err_total;

    function automatic logic [BYTES_W-1:0] add_sat(input logic [BYTES_W-1:0] a,
                                                   input logic [BYTES_W-1:0] b);
        logic [BYTES_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[BYTES_W] ? {BYTES_W{1'b1}} : total[BYTES_W-1:0];
    endfunction

    function automatic logic [BYTES_W-1:0] live_sum();
        logic [BYTES_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) begin
                acc = add_sat(acc, slot_amount[i]);
            end
        end
        return acc;
    endfunction

    function automatic quota_report_t apply_quota_op(input func_t fn,
                                                     input logic [SLOT_W-1:0] slot,
                                                     input logic [BYTES_W-1:0] nbytes,
                                                     input logic [MONTH_W-1:0] month);
        quota_report_t      rep;
        logic               accounting;
        logic [BYTES_W-1:0] after;
        rep.allowed = 1'b1;
        rep.status  = 1'b0;
        accounting  = q_enabled && (q_limit != '0);
        // release never looks at the period
        if (fn != FN_RELEASE && !(have_month && period == month)) begin
            period     = month;
            have_month = 1'b1;
            used_total = '0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_live[i] = 1'b0;
            end
        end
        case (fn)
            FN_RESERVE: begin
                if (accounting) begin
                    after = add_sat(add_sat(used_total, live_sum()), nbytes);
                    if (after > q_limit && q_hard) begin
                        rep.allowed = 1'b0;
                        rep.status  = 1'b1;
                    end else if (slot < SLOTS) begin
                        slot_live[slot]   = 1'b1;
                        slot_amount[slot] = nbytes;
                    end
                end
            end
            FN_COMMIT: begin
                if (slot < SLOTS) begin
                    slot_live[slot] = 1'b0;
                end
                if (accounting) begin
                    used_total = add_sat(used_total, nbytes);
                end
            end
            FN_RELEASE: begin
                if (slot < SLOTS) begin
                    slot_live[slot] = 1'b0;
                end
            end
            default: ;
        endcase
        rep.used     = used_total;
        rep.reserved = live_sum();
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [BYTES_W-1:0] exp_val,
                               input logic [BYTES_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
            err_total++;
        end
    endtask

    always @(posedge aclk) begin
        quota_report_t want;
        if (!aresetn) begin
            q_enabled  = 1'b0;
            q_limit    = '0;
            q_hard     = 1'b1;
            period     = '0;
            have_month = 1'b0;
            used_total = '0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_live[i]   = 1'b0;
                slot_amount[i] = '0;
            end
            quota_reports_q.delete();
            err_total = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_QUOTA_EN: q_enabled = cfg_data[0];
                    CFG_LIMIT:    q_limit   = cfg_data;
                    CFG_HARD:     q_hard    = cfg_data[0];
                    default: ;
                endcase
            end
            // the result side goes first so a beat taken on this edge is not matched against itself
            if (m_tvalid && m_tready) begin
                if (quota_reports_q.size() == 0) begin
                    $display("%0t: result beat mismatch, expected no beat, got %0h",
                             $time, m_tdata);
                    err_total++;
                end else begin
                    want = quota_reports_q.pop_front();
                    check_field("allowed", {63'd0, want.allowed}, {63'd0, m_tdata[0]});
                    check_field("status", {63'd0, want.status}, {63'd0, m_tdata[1]});
                    check_field("used_bytes", want.used, m_tdata[65:2]);
                    check_field("reserved_bytes", want.reserved, m_tdata[129:66]);
                end
            end
            if (s_tvalid && s_tready) begin
                quota_reports_q.push_back(apply_quota_op(func_t'(s_tuser), s_tdata[3:0],
                                                         s_tdata[67:4], s_tdata[83:68]));
            end
        end
        mismatches  <= err_total;
        outstanding <= quota_reports_q.size();
    end

endmodule

// File: tb/byte_quota_reservation_tracker_top_tb.sv
`timescale 1ns / 1ps

module byte_quota_reservation_tracker_top_tb;
    import bqrt_pkg::*;

    localparam int SLOTS         = 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASE_ITEMS   = 56;
    localparam logic [BYTES_W-1:0] ALL_ONES = {BYTES_W{1'b1}};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [87:0]          s_tdata   = '0;
    logic [FUNC_W-1:0]    s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [135:0]         m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTES_W-1:0]   cfg_data  = '0;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    int burst_left  = 0;
    bit steady      = 1'b0;
    int rx_mode     = 0;
    bit hold_req    = 1'b0;
    int op_count [4] = '{0, 0, 0, 0};
    int op_total    = 0;
    int cfg_writes  = 0;
    int settings_run = 0;

    byte_quota_reservation_tracker_top #(
        .SLOTS(SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    quota_tracker_checker #(
        .SLOTS(SLOTS)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side back-pressure
    initial begin : rx_side
        int rx_cnt;
        rx_cnt = 0;
        forever begin
            @(posedge aclk);
            rx_cnt++;
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 99) < 75);
                    2: m_tready <= ((rx_cnt % 7) < 5);
                    default: m_tready <= ($urandom_range(0, 99) < 25);
                endcase
            end
        end
    end

    function automatic logic [BYTES_W-1:0] rand_bytes(input logic [BYTES_W-1:0] lim);
        logic [BYTES_W-1:0] wide;
        logic [BYTES_W-1:0] scale;
        wide  = {$urandom, $urandom};
        scale = (lim == '0) ? 64'd100000 : lim;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2, 3:    return wide;
            4:       return scale - (wide % ((scale >> 3) + 1));
            default: return wide % ((scale >> 2) + 1);
        endcase
    endfunction

    task automatic send_op(input func_t fn, input logic [SLOT_W-1:0] slot,
                           input logic [BYTES_W-1:0] nbytes, input logic [MONTH_W-1:0] month);
        int gap;
        if (burst_left == 0) begin
            gap = steady ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {4'b0, month, nbytes, slot};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        op_count[fn]++;
        op_total++;
    endtask

    // drop valid on the last accepting edge, then wait for every result and the pipeline tail
    task automatic quiesce();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [BYTES_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        @(posedge aclk);
    endtask

    task automatic set_quota(input logic en, input logic [BYTES_W-1:0] lim, input logic hard);
        quiesce();
        write_reg(CFG_QUOTA_EN, {63'd0, en});
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_HARD, {63'd0, hard});
        settings_run++;
    endtask

    initial begin : stim
        logic               en;
        logic [BYTES_W-1:0] lim;
        logic               hard;
        logic [MONTH_W-1:0] cur_month;
        logic [SLOT_W-1:0]  s;
        bit                 hold_done;
        int                 phase_start;
        hold_done = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // accounting off after reset: nothing recorded, nothing added
        send_op(FN_RESERVE, 4'd3, 64'd500, 16'd10);
        send_op(FN_COMMIT, 4'd3, 64'd400, 16'd10);

        set_quota(1'b1, 64'd1000, 1'b1);
        send_op(FN_RESERVE, 4'd0, 64'd500, 16'd10);
        send_op(FN_RESERVE, 4'd1, 64'd600, 16'd10);
        // lands exactly on the limit
        send_op(FN_RESERVE, 4'd1, 64'd500, 16'd10);
        send_op(FN_SNAPSHOT, 4'd9, ALL_ONES, 16'd10);
        send_op(FN_COMMIT, 4'd0, 64'd300, 16'd10);
        // commit on a free slot still counts
        send_op(FN_COMMIT, 4'd7, 64'd100, 16'd10);
        // release with a foreign month leaves the period alone
        send_op(FN_RELEASE, 4'd1, 64'd77, 16'hFFFF);
        send_op(FN_SNAPSHOT, 4'd0, 64'd0, 16'd10);
        send_op(FN_RESERVE, 4'd15, ALL_ONES, 16'd10);
        send_op(FN_RESERVE, 4'd2, 64'd0, 16'd10);
        send_op(FN_SNAPSHOT, 4'd2, 64'd0, 16'd11);
        send_op(FN_RESERVE, 4'd4, 64'd200, 16'hFFFF);
        send_op(FN_SNAPSHOT, 4'd4, 64'd0, 16'd0);

        // soft mode: over the limit still admitted, sums saturate
        set_quota(1'b1, 64'd1000, 1'b0);
        send_op(FN_RESERVE, 4'd5, 64'd5000, 16'd0);
        send_op(FN_RESERVE, 4'd6, ALL_ONES, 16'd0);
        send_op(FN_RESERVE, 4'd7, ALL_ONES, 16'd0);
        send_op(FN_COMMIT, 4'd8, ALL_ONES, 16'd0);
        send_op(FN_COMMIT, 4'd9, 64'd1, 16'd0);
        send_op(FN_RELEASE, 4'd5, 64'd0, 16'd0);

        set_quota(1'b1, ALL_ONES, 1'b1);
        send_op(FN_RESERVE, 4'd10, ALL_ONES, 16'd0);
        send_op(FN_SNAPSHOT, 4'd10, 64'd0, 16'd0);

        set_quota(1'b0, ALL_ONES, 1'b1);
        send_op(FN_COMMIT, 4'd11, 64'd12345, 16'd0);
        send_op(FN_RESERVE, 4'd12, 64'd99, 16'd1);

        cur_month = 16'($urandom_range(0, 65535));
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin en = 1'b1; lim = 64'd10000; hard = 1'b1; end
                1: begin en = 1'b1; lim = 64'd10000; hard = 1'b0; end
                2: begin en = 1'b1; lim = 64'd50000; hard = 1'b1; end
                3: begin en = 1'b0; lim = 64'd5000;  hard = 1'b1; end
                4: begin en = 1'b1; lim = 64'd0;     hard = 1'b1; end
                5: begin en = 1'b1; lim = ALL_ONES;  hard = 1'b1; end
                6: begin en = 1'b1; lim = 64'd1;     hard = 1'b1; end
                default: begin
                    en   = 1'b1;
                    lim  = {$urandom, $urandom} >> $urandom_range(0, 40);
                    hard = 1'b0;
                end
            endcase
            set_quota(en, lim, hard);
            rx_mode     = ph % 4;
            steady      = (ph == 2 || ph == 4);
            phase_start = op_total;
            while (op_total - phase_start < PHASE_ITEMS) begin
                // sender keeps pushing while results are held back, so the block backs up
                if (ph == 2 && !hold_done && op_total - phase_start >= 8) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                if ($urandom_range(0, 19) == 0) begin
                    cur_month = ($urandom_range(0, 1) == 0) ? cur_month + 16'd1
                                                            : 16'($urandom_range(0, 65535));
                end
                if ($urandom_range(0, 4) != 0) begin
                    // reservation lifecycle on one slot
                    s = 4'($urandom_range(0, 15));
                    send_op(FN_RESERVE, s, rand_bytes(lim), cur_month);
                    if ($urandom_range(0, 2) == 0) begin
                        send_op(FN_SNAPSHOT, 4'($urandom_range(0, 15)), {$urandom, $urandom},
                                cur_month);
                    end
                    case ($urandom_range(0, 3))
                        0: send_op(FN_COMMIT, s, rand_bytes(lim), cur_month);
                        1: send_op(FN_RELEASE, s, {$urandom, $urandom},
                                   ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                               : cur_month);
                        default: ;
                    endcase
                end else begin
                    send_op(func_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                            rand_bytes(lim),
                            ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                        : cur_month);
                end
            end
        end

        quiesce();
        $display("covered %0d operations: %0d reserve, %0d commit, %0d release, %0d snapshot",
                 op_total, op_count[FN_RESERVE], op_count[FN_COMMIT], op_count[FN_RELEASE],
                 op_count[FN_SNAPSHOT]);
        $display("%0d register writes across %0d quota settings, one long result stall",
                 cfg_writes, settings_run);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
